### sv/alp_pkg.sv
// Shared constants and types for the address lease pool allocator.
package alp_pkg;

  localparam int POOL_DEPTH = 32;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 6;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;
  localparam int ENTRY_W    = MAC_W + TIME_W;

  localparam logic [ADDR_W-1:0] HOST_OFFSET = 32'd51;

  localparam logic [TIME_W-1:0] LEASE_DURATION_RST = 32'd108000;
  localparam logic [SIZE_W-1:0] POOL_SIZE_RST      = 6'd20;
  localparam logic [ADDR_W-1:0] BASE_ADDRESS_RST   = 32'hC0A8_0101;
  localparam logic [ADDR_W-1:0] SUBNET_MASK_RST    = 32'hFFFF_FF00;

  typedef enum logic [1:0] {
    REG_LEASE_DURATION = 2'd0,
    REG_POOL_SIZE      = 2'd1,
    REG_BASE_ADDRESS   = 2'd2,
    REG_SUBNET_MASK    = 2'd3
  } cfg_reg_t;

endpackage

### sv/alp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/address_lease_pool_allocator.sv
// Top level of the first-fit address lease pool allocator.
//
// Channel | Direction | Handshake                 | Payload
// in_     | slave     | in_tvalid / in_tready     | in_tdata: client_mac, req_time
// out_    | master    | out_tvalid / out_tready   | out_tuser: granted; out_tdata: addr, index
// cfg_    | slave     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// The scan reads at most the pool size in entries, capped at 32: one read of
// the lease RAM per cycle while not stalled, pipelined against the compare
// of the entry read before it. Reset (rst_n low, synchronous) clears the
// in-use bits and the output valid bit, and loads the configuration registers
// with their reset values; the RAM and the output data are left as is. The scan
// freezes while a result waits in the output register and out_tready is low.
module address_lease_pool_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // client_mac [47:0], req_time [79:48]
  input  logic [alp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // offered_address [31:0], entry_index [36:32], zero [39:37]
  output logic [alp_pkg::OUT_DATA_W-1:0] out_tdata,
  // granted [0]
  output logic                           out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);

  import alp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [TIME_W-1:0] lease_duration_r;
  logic [SIZE_W-1:0] pool_size_r;
  logic [ADDR_W-1:0] base_address_r;
  logic [ADDR_W-1:0] subnet_mask_r;

  // Request captured at accept
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;

  // Scan pipeline: read issue counter and the entry under compare
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;

  // Per-entry in-use bits
  logic [POOL_DEPTH-1:0] in_use_r, in_use_nxt;

  // Output register
  logic                  out_vld_r, out_vld_nxt;
  logic                  out_grant_r, out_grant_nxt;
  logic [ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;

  // RAM port signals
  logic               ram_wr_en;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic              stall;
  logic              hit;
  logic [TIME_W-1:0] lease_end_rd;
  logic [CNT_W-1:0]  pool_size_ext;
  logic [CNT_W-1:0]  depth_cnt;
  logic [ADDR_W-1:0] net_addr;

  assign pool_size_ext = CNT_W'(pool_size_r);
  assign depth_cnt     = CNT_W'(POOL_DEPTH);
  assign net_addr      = base_address_r & subnet_mask_r;
  assign lease_end_rd  = ram_rd_data[TIME_W-1:0];

  // Hold the scan while a finished result cannot leave
  assign stall = out_vld_r && !out_tready;

  // Entry is taken if free or if its lease has run out
  assign hit = chk_vld_r && (!in_use_r[chk_idx_r] || (now_r >= lease_end_rd));

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_grant_r;
  assign out_tdata  = {{(OUT_DATA_W - ADDR_W - IDX_W){1'b0}}, out_idx_r, out_addr_r};

  assign ram_wr_en   = (state_r == ST_SCAN) && !stall && hit;
  assign ram_wr_data = {mac_r, now_r + lease_duration_r};
  assign ram_rd_en   = (state_r == ST_SCAN) && !stall && !hit && (rd_idx_r < limit_r);

  alp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (chk_idx_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    mac_nxt       = mac_r;
    now_nxt       = now_r;
    limit_nxt     = limit_r;
    rd_idx_nxt    = rd_idx_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    in_use_nxt    = in_use_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_grant_nxt = out_grant_r;
    out_addr_nxt  = out_addr_r;
    out_idx_nxt   = out_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // Capture the request and the scan bound, capped at pool depth
          mac_nxt     = in_tdata[MAC_W-1:0];
          now_nxt     = in_tdata[MAC_W +: TIME_W];
          limit_nxt   = (pool_size_ext > depth_cnt) ? depth_cnt : pool_size_ext;
          rd_idx_nxt  = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (hit) begin
            // Claim the entry and report its address
            in_use_nxt[chk_idx_r] = 1'b1;
            out_vld_nxt   = 1'b1;
            out_grant_nxt = 1'b1;
            out_addr_nxt  = net_addr + HOST_OFFSET + ADDR_W'(chk_idx_r);
            out_idx_nxt   = chk_idx_r;
            chk_vld_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end else if (rd_idx_r < limit_r) begin
            // Advance: read the next entry and queue it for the compare
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          end else begin
            // Pool exhausted
            out_vld_nxt   = 1'b1;
            out_grant_nxt = 1'b0;
            out_addr_nxt  = '0;
            out_idx_nxt   = '0;
            chk_vld_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      chk_vld_r        <= 1'b0;
      rd_idx_r         <= '0;
      in_use_r         <= '0;
      out_vld_r        <= 1'b0;
      lease_duration_r <= LEASE_DURATION_RST;
      pool_size_r      <= POOL_SIZE_RST;
      base_address_r   <= BASE_ADDRESS_RST;
      subnet_mask_r    <= SUBNET_MASK_RST;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      rd_idx_r  <= rd_idx_nxt;
      in_use_r  <= in_use_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LEASE_DURATION: lease_duration_r <= cfg_data;
          REG_POOL_SIZE:      pool_size_r      <= cfg_data[SIZE_W-1:0];
          REG_BASE_ADDRESS:   base_address_r   <= cfg_data;
          REG_SUBNET_MASK:    subnet_mask_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    mac_r       <= mac_nxt;
    now_r       <= now_nxt;
    limit_r     <= limit_nxt;
    chk_idx_r   <= chk_idx_nxt;
    out_grant_r <= out_grant_nxt;
    out_addr_r  <= out_addr_nxt;
    out_idx_r   <= out_idx_nxt;
  end

endmodule
